/* design/majority_gate_constraint_solver_core_assert.svh */
// ----------------------------------------------------------------------------
// Majority gate constraint solver - assertion macros
// Shared concurrent assertion forms for the solver checker.
// ----------------------------------------------------------------------------
`ifndef MAJORITY_GATE_CONSTRAINT_SOLVER_CORE_ASSERT_SVH
`define MAJORITY_GATE_CONSTRAINT_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define MGCS_CHK_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("majority gate solver check failed");

// Implication from the accept edge to the result strobe
`define MGCS_CHK_LAT2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("majority gate solver latency check failed");

`endif

/* design/mgcs_pkg.sv */
// ----------------------------------------------------------------------------
// mgcs_pkg
// Cell codes, status codes, result record and ternary helpers for the
// majority gate constraint solver.
// ----------------------------------------------------------------------------
package mgcs_pkg;

	// Ternary cell codes; code three is folded into unknown
	localparam logic [1:0] CELL_ZERO = 2'd0;
	localparam logic [1:0] CELL_ONE  = 2'd1;
	localparam logic [1:0] CELL_UNK  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_WAIT     = 2'd0;
	localparam logic [1:0] ST_CHANGED  = 2'd1;
	localparam logic [1:0] ST_CLOSED   = 2'd2;
	localparam logic [1:0] ST_CONFLICT = 2'd3;

	typedef logic [1:0] cell_t;

	typedef struct packed {
		logic [1:0] status;
		cell_t      out_a;
		cell_t      out_b;
		cell_t      out_m;
		cell_t      out_r;
		cell_t      out_e;
		logic [7:0] support_mask;
		logic [1:0] open_areas;
		logic       base_refine_needed;
		logic       direct_flag;
	} mgcs_result_t;

	// Fold the unused code into unknown
	function automatic cell_t norm_cell(input logic [1:0] v);
		norm_cell = (v >= CELL_UNK) ? CELL_UNK : v;
	endfunction

	// Majority of three normalized ternary cells, unknown if undetermined
	function automatic cell_t tern_maj(input cell_t a, input cell_t b, input cell_t m);
		if (a == b && a != CELL_UNK)
			tern_maj = a;
		else if (a == m && a != CELL_UNK)
			tern_maj = a;
		else if (b == m && b != CELL_UNK)
			tern_maj = b;
		else
			tern_maj = CELL_UNK;
	endfunction

endpackage

/* design/majority_gate_constraint_solver_core.sv */
// ----------------------------------------------------------------------------
// majority_gate_constraint_solver_core
// Pipeline: a transaction accepted at an edge is held in the input register,
//   evaluated combinationally and strobed on done from the result register.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: arst_n clears the valid pipeline so done is low; payload is not reset.
// ----------------------------------------------------------------------------
module majority_gate_constraint_solver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] value_a,
	input  logic [1:0] value_b,
	input  logic [1:0] value_m,
	input  logic [1:0] value_r,
	input  logic [1:0] value_e,
	input  logic [7:0] allowed_mask,
	output logic       done,
	output logic [1:0] status,
	output logic [1:0] out_a,
	output logic [1:0] out_b,
	output logic [1:0] out_m,
	output logic [1:0] out_r,
	output logic [1:0] out_e,
	output logic [7:0] support_mask,
	output logic [1:0] open_areas,
	output logic       base_refine_needed,
	output logic       direct_flag
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic [1:0]            value_a_s1, value_b_s1, value_m_s1, value_r_s1, value_e_s1;
	logic [7:0]            allowed_mask_s1;
	mgcs_pkg::mgcs_result_t eval_res;
	mgcs_pkg::mgcs_result_t res_s2;

	// Never stall: every cycle can take a new transaction
	assign busy = 1'b0;

	// Advance the valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the query on accept
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			value_a_s1      <= value_a;
			value_b_s1      <= value_b;
			value_m_s1      <= value_m;
			value_r_s1      <= value_r;
			value_e_s1      <= value_e;
			allowed_mask_s1 <= allowed_mask;
		end
	end

	mgcs_eval u_eval (
		.value_a      (value_a_s1),
		.value_b      (value_b_s1),
		.value_m      (value_m_s1),
		.value_r      (value_r_s1),
		.value_e      (value_e_s1),
		.allowed_mask (allowed_mask_s1),
		.result       (eval_res)
	);

	// Hold the result for its strobe cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= eval_res;
		end
	end

	assign done               = valid_s2;
	assign status             = res_s2.status;
	assign out_a              = res_s2.out_a;
	assign out_b              = res_s2.out_b;
	assign out_m              = res_s2.out_m;
	assign out_r              = res_s2.out_r;
	assign out_e              = res_s2.out_e;
	assign support_mask       = res_s2.support_mask;
	assign open_areas         = res_s2.open_areas;
	assign base_refine_needed = res_s2.base_refine_needed;
	assign direct_flag        = res_s2.direct_flag;

endmodule

/* design/mgcs_eval.sv */
// ----------------------------------------------------------------------------
// mgcs_eval
// One-pass evaluation of a gate query: support enumeration over the eight
// base assignments, open-area count, status decision and cell refinement.
// ----------------------------------------------------------------------------
module mgcs_eval (
	input  logic [1:0]            value_a,
	input  logic [1:0]            value_b,
	input  logic [1:0]            value_m,
	input  logic [1:0]            value_r,
	input  logic [1:0]            value_e,
	input  logic [7:0]            allowed_mask,
	output mgcs_pkg::mgcs_result_t result
);

	mgcs_pkg::cell_t ca, cb, cm, cr, ce;
	mgcs_pkg::cell_t ra, rb, rm, rr, re;
	mgcs_pkg::cell_t dm;
	logic            ua, ub, um, ur, ue;
	logic            base_undet;
	logic [1:0]      areas;
	logic [7:0]      support;
	logic [2:0]      seen0, seen1;
	logic [2:0]      idx;
	logic            maj_bit;
	logic            changed;
	logic [1:0]      status;
	logic            refine, direct;

	// Normalize cells and flag unknowns
	always_comb begin
		ca = mgcs_pkg::norm_cell(value_a);
		cb = mgcs_pkg::norm_cell(value_b);
		cm = mgcs_pkg::norm_cell(value_m);
		cr = mgcs_pkg::norm_cell(value_r);
		ce = mgcs_pkg::norm_cell(value_e);
		ua = (ca == mgcs_pkg::CELL_UNK);
		ub = (cb == mgcs_pkg::CELL_UNK);
		um = (cm == mgcs_pkg::CELL_UNK);
		ur = (cr == mgcs_pkg::CELL_UNK);
		ue = (ce == mgcs_pkg::CELL_UNK);
		base_undet = (ua & ub) | (ua & um) | (ub & um);
		areas = 2'({1'b0, base_undet} + {1'b0, ur} + {1'b0, ue});
		dm = mgcs_pkg::tern_maj(ca, cb, cm);
	end

	// Enumerate the eight base assignments and collect per-bit agreement
	always_comb begin
		support = '0;
		seen0   = '0;
		seen1   = '0;
		idx     = '0;
		maj_bit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			idx     = 3'(i);
			maj_bit = (idx[2] & idx[1]) | (idx[2] & idx[0]) | (idx[1] & idx[0]);
			support[i] = allowed_mask[i]
				&& (ua || ca[0] == idx[2])
				&& (ub || cb[0] == idx[1])
				&& (um || cm[0] == idx[0])
				&& (ur || ue || ((maj_bit ^ ce[0]) == cr[0]));
		end
		for (int i = 0; i < 8; i++) begin
			idx = 3'(i);
			for (int p = 0; p < 3; p++) begin
				if (support[i]) begin
					if (idx[p])
						seen1[p] = 1'b1;
					else
						seen0[p] = 1'b1;
				end
			end
		end
	end

	// Decide status and refine cells
	always_comb begin
		ra = ca;
		rb = cb;
		rm = cm;
		rr = cr;
		re = ce;
		refine = 1'b0;
		direct = 1'b0;
		status = mgcs_pkg::ST_WAIT;
		if (support == 8'd0) begin
			status = mgcs_pkg::ST_CONFLICT;
		end else if (areas >= 2'd2) begin
			status = mgcs_pkg::ST_WAIT;
		end else if (areas == 2'd0) begin
			if (dm == mgcs_pkg::CELL_UNK) begin
				refine = 1'b1;
				status = mgcs_pkg::ST_WAIT;
			end else begin
				status = mgcs_pkg::ST_CLOSED;
				direct = (ce == mgcs_pkg::CELL_ZERO);
			end
		end else begin
			if (base_undet) begin
				// seen bit 2 is a, bit 1 is b, bit 0 is m
				if (ua && (seen0[2] != seen1[2]))
					ra = {1'b0, seen1[2]};
				if (ub && (seen0[1] != seen1[1]))
					rb = {1'b0, seen1[1]};
				if (um && (seen0[0] != seen1[0]))
					rm = {1'b0, seen1[0]};
			end else if (dm != mgcs_pkg::CELL_UNK) begin
				if (ur)
					rr = {1'b0, dm[0] ^ ce[0]};
				if (ue)
					re = {1'b0, dm[0] ^ cr[0]};
			end
			status = changed ? mgcs_pkg::ST_CHANGED : mgcs_pkg::ST_WAIT;
		end
	end

	assign changed = (ra != ca) || (rb != cb) || (rm != cm) || (rr != cr) || (re != ce);

	// Pack the result record
	always_comb begin
		result.status             = status;
		result.out_a              = ra;
		result.out_b              = rb;
		result.out_m              = rm;
		result.out_r              = rr;
		result.out_e              = re;
		result.support_mask       = support;
		result.open_areas         = areas;
		result.base_refine_needed = refine;
		result.direct_flag        = direct;
	end

endmodule

/* design/mgcs_checker.sv */
// ----------------------------------------------------------------------------
// mgcs_checker
// Port-level checks for the majority gate solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "majority_gate_constraint_solver_core_assert.svh"

module mgcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] support_mask,
	input logic [1:0] open_areas,
	input logic       base_refine_needed,
	input logic       direct_flag
);

	// Each accepted transaction strobes a result on done
	`MGCS_CHK_LAT2(a_accept_to_done, start && !busy, done)

	// Conflict exactly when no assignment is supported
	`MGCS_CHK_NOW(a_conflict_iff_empty, done, (status == mgcs_pkg::ST_CONFLICT) == (support_mask == 8'd0))

	// Closed needs no open area and no refinement request
	`MGCS_CHK_NOW(a_closed_is_closed, done && status == mgcs_pkg::ST_CLOSED, open_areas == 2'd0 && !base_refine_needed)

	// Direct flag only on a closed gate
	`MGCS_CHK_NOW(a_direct_only_closed, done && direct_flag, status == mgcs_pkg::ST_CLOSED)

endmodule

bind majority_gate_constraint_solver_core mgcs_checker u_mgcs_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.done               (done),
	.status             (status),
	.support_mask       (support_mask),
	.open_areas         (open_areas),
	.base_refine_needed (base_refine_needed),
	.direct_flag        (direct_flag)
);
